@@ hw/rtl/pcs_pkg.sv @@
`timescale 1ns / 1ps
// pcs_pkg: shared types, constants and helpers of the pid controller step unit
// holds beat structs, register indexes, microcode words and the control program
// no dependencies
package pcs_pkg;

	localparam int VALUE_W    = 32;
	localparam int FRAC_W     = 16;
	localparam int STEP_W     = 24;
	localparam int WINDUP_W   = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int ACC_W      = VALUE_W + 2;
	localparam int PROD_W     = 2 * VALUE_W;
	localparam int DIV_NUM_W  = VALUE_W + FRAC_W;
	localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
	localparam int UPC_W      = 4;

	localparam logic signed [VALUE_W-1:0] VMAX     = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VMIN     = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [VALUE_W-1:0] GAIN_ONE = VALUE_W'(64'd1 << FRAC_W);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDUP_LIMIT  = 3'd5;

	typedef struct packed {
		logic signed [VALUE_W-1:0] measured_value;
		logic signed [VALUE_W-1:0] setpoint;
		logic        [STEP_W-1:0]  time_step;
	} in_beat_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] drive;
		logic                      held;
	} out_beat_t;

	// datapath actions
	localparam logic [2:0] ACT_NONE      = 3'd0;
	localparam logic [2:0] ACT_FETCH     = 3'd1;
	localparam logic [2:0] ACT_ERR       = 3'd2;
	localparam logic [2:0] ACT_DIV_START = 3'd3;
	localparam logic [2:0] ACT_INTEG     = 3'd4;
	localparam logic [2:0] ACT_DRIVE     = 3'd5;
	localparam logic [2:0] ACT_EMIT      = 3'd6;

	// multiplier operand pairs
	localparam logic [1:0] MS_ERR_DT = 2'd0;
	localparam logic [1:0] MS_P_ERR  = 2'd1;
	localparam logic [1:0] MS_I_INT  = 2'd2;
	localparam logic [1:0] MS_D_DER  = 2'd3;

	// accumulator operations
	localparam logic [1:0] ACC_NONE = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	// sequencing
	localparam logic [2:0] JC_NEXT     = 3'd0;
	localparam logic [2:0] JC_GOTO     = 3'd1;
	localparam logic [2:0] JC_IF_HOLD  = 3'd2;
	localparam logic [2:0] JC_WAIT_IN  = 3'd3;
	localparam logic [2:0] JC_WAIT_DIV = 3'd4;
	localparam logic [2:0] JC_WAIT_OUT = 3'd5;

	// program steps
	localparam logic [UPC_W-1:0] UPC_FETCH    = 4'd0;
	localparam logic [UPC_W-1:0] UPC_ERR      = 4'd1;
	localparam logic [UPC_W-1:0] UPC_START    = 4'd2;
	localparam logic [UPC_W-1:0] UPC_INTEG    = 4'd3;
	localparam logic [UPC_W-1:0] UPC_MUL_P    = 4'd4;
	localparam logic [UPC_W-1:0] UPC_MUL_I    = 4'd5;
	localparam logic [UPC_W-1:0] UPC_ADD_I    = 4'd6;
	localparam logic [UPC_W-1:0] UPC_WAIT_DIV = 4'd7;
	localparam logic [UPC_W-1:0] UPC_MUL_D    = 4'd8;
	localparam logic [UPC_W-1:0] UPC_ADD_D    = 4'd9;
	localparam logic [UPC_W-1:0] UPC_DRIVE    = 4'd10;
	localparam logic [UPC_W-1:0] UPC_EMIT     = 4'd11;

	typedef struct packed {
		logic [2:0]       act;
		logic             mul_en;
		logic [1:0]       mul_sel;
		logic [1:0]       acc_op;
		logic [2:0]       jc;
		logic [UPC_W-1:0] target;
	} ucw_t;

	// control store
	function automatic ucw_t ucode(input logic [UPC_W-1:0] upc);
		ucw_t w;
		unique case (upc)
			UPC_FETCH:    w = '{ACT_FETCH,     1'b0, MS_ERR_DT, ACC_NONE, JC_WAIT_IN,  UPC_ERR};
			UPC_ERR:      w = '{ACT_ERR,       1'b0, MS_ERR_DT, ACC_NONE, JC_IF_HOLD,  UPC_EMIT};
			UPC_START:    w = '{ACT_DIV_START, 1'b1, MS_ERR_DT, ACC_NONE, JC_NEXT,     UPC_FETCH};
			UPC_INTEG:    w = '{ACT_INTEG,     1'b0, MS_ERR_DT, ACC_NONE, JC_NEXT,     UPC_FETCH};
			UPC_MUL_P:    w = '{ACT_NONE,      1'b1, MS_P_ERR,  ACC_NONE, JC_NEXT,     UPC_FETCH};
			UPC_MUL_I:    w = '{ACT_NONE,      1'b1, MS_I_INT,  ACC_LOAD, JC_NEXT,     UPC_FETCH};
			UPC_ADD_I:    w = '{ACT_NONE,      1'b0, MS_ERR_DT, ACC_ADD,  JC_NEXT,     UPC_FETCH};
			UPC_WAIT_DIV: w = '{ACT_NONE,      1'b0, MS_ERR_DT, ACC_NONE, JC_WAIT_DIV, UPC_MUL_D};
			UPC_MUL_D:    w = '{ACT_NONE,      1'b1, MS_D_DER,  ACC_NONE, JC_NEXT,     UPC_FETCH};
			UPC_ADD_D:    w = '{ACT_NONE,      1'b0, MS_ERR_DT, ACC_ADD,  JC_NEXT,     UPC_FETCH};
			UPC_DRIVE:    w = '{ACT_DRIVE,     1'b0, MS_ERR_DT, ACC_NONE, JC_NEXT,     UPC_FETCH};
			UPC_EMIT:     w = '{ACT_EMIT,      1'b0, MS_ERR_DT, ACC_NONE, JC_WAIT_OUT, UPC_FETCH};
			default:      w = '{ACT_NONE,      1'b0, MS_ERR_DT, ACC_NONE, JC_GOTO,     UPC_FETCH};
		endcase
		return w;
	endfunction

	// saturate a slightly wider signed value into VALUE_W bits
	function automatic logic signed [VALUE_W-1:0] sat_wide(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-VALUE_W:0] top;
		top = v[ACC_W-1:VALUE_W-1];
		if ((&top) || !(|top))
			return v[VALUE_W-1:0];
		else if (v[ACC_W-1])
			return VMIN;
		else
			return VMAX;
	endfunction

	// product scaled down by the fraction bits, floor, saturated
	function automatic logic signed [VALUE_W-1:0] mul_round(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] sh;
		logic [PROD_W-VALUE_W:0]  top;
		sh  = p >>> FRAC_W;
		top = sh[PROD_W-1:VALUE_W-1];
		if ((&top) || !(|top))
			return sh[VALUE_W-1:0];
		else if (sh[PROD_W-1])
			return VMIN;
		else
			return VMAX;
	endfunction

endpackage

@@ hw/rtl/pcs_div.sv @@
`timescale 1ns / 1ps
// pcs_div: bit-serial restoring divider for the derivative term
// computes (dividend << FRAC_W) / divisor truncated toward zero, saturated; uses pcs_pkg
module pcs_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [pcs_pkg::VALUE_W:0]       dividend,
	input  logic        [pcs_pkg::STEP_W-1:0]      divisor,
	output logic                                   busy,
	output logic signed [pcs_pkg::VALUE_W-1:0]     quotient
);

	localparam logic [pcs_pkg::VALUE_W-1:0] LIM_NEG = {1'b1, {(pcs_pkg::VALUE_W-1){1'b0}}};
	localparam logic [pcs_pkg::VALUE_W-1:0] LIM_POS = {1'b0, {(pcs_pkg::VALUE_W-1){1'b1}}};

	logic                                 busy_q;
	logic [pcs_pkg::DIV_CNT_W-1:0]        cnt_q;
	logic [pcs_pkg::DIV_NUM_W-1:0]        num_q;
	logic [pcs_pkg::STEP_W-1:0]           rem_q;
	logic [pcs_pkg::STEP_W-1:0]           dvs_q;
	logic [pcs_pkg::VALUE_W-1:0]          quo_q;
	logic                                 ovf_q;
	logic                                 neg_q;
	logic signed [pcs_pkg::VALUE_W-1:0]   res_q;

	logic signed [pcs_pkg::VALUE_W:0]     mag_full;
	logic [pcs_pkg::STEP_W:0]             trial;
	logic                                 fits;
	logic [pcs_pkg::STEP_W:0]             rem_sub;
	logic                                 iterate;
	logic                                 finish;
	logic signed [pcs_pkg::VALUE_W-1:0]   res_new;

	assign mag_full = dividend[pcs_pkg::VALUE_W] ? -dividend : dividend;
	assign trial    = {rem_q, num_q[pcs_pkg::DIV_NUM_W-1]};
	assign fits     = trial >= {1'b0, dvs_q};
	assign rem_sub  = trial - {1'b0, dvs_q};
	assign iterate  = busy_q && (cnt_q != '0);
	assign finish   = busy_q && (cnt_q == '0);

	always_comb begin
		if (neg_q) begin
			if (ovf_q || (quo_q > LIM_NEG))
				res_new = LIM_NEG;
			else
				res_new = -quo_q;
		end else begin
			if (ovf_q || (quo_q > LIM_POS))
				res_new = LIM_POS;
			else
				res_new = quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= pcs_pkg::DIV_CNT_W'(pcs_pkg::DIV_NUM_W);
		end else if (iterate) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (finish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[pcs_pkg::VALUE_W];
			num_q <= {mag_full[pcs_pkg::VALUE_W-1:0], {pcs_pkg::FRAC_W{1'b0}}};
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (iterate) begin
			num_q <= {num_q[pcs_pkg::DIV_NUM_W-2:0], 1'b0};
			rem_q <= fits ? rem_sub[pcs_pkg::STEP_W-1:0] : trial[pcs_pkg::STEP_W-1:0];
			quo_q <= {quo_q[pcs_pkg::VALUE_W-2:0], fits};
			ovf_q <= ovf_q | quo_q[pcs_pkg::VALUE_W-1];
		end
		if (finish)
			res_q <= res_new;
	end

	assign busy     = busy_q;
	assign quotient = res_q;

endmodule

@@ hw/rtl/pid_controller_step_unit.sv @@
`timescale 1ns / 1ps
// pid_controller_step_unit: top level of the fixed-point pid step with integral clamp
// microcoded sequencer over one shared multiplier and accumulator; uses pcs_pkg, pcs_div
//
// One beat in gives one beat out; the next beat is accepted only after the last one
// is emitted. For a beat with a nonzero time step the bit-serial divider for the
// derivative runs 48 steps and then saturates, and the sequencer waits on it
// before the last multiply. A zero time step skips the arithmetic and repeats the
// last drive with held set. Values are signed Q16.16, the time step unsigned Q8.16. The
// output register lets the next beat in while a result waits. Write gains and limits
// through cfg_wen/cfg_index/cfg_wdata only while no beat is in flight; unknown indexes
// are ignored. Reset sets gain_p = 1.0 and zeroes other settings and controller state.
module pid_controller_step_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  pcs_pkg::in_beat_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output pcs_pkg::out_beat_t                  out_data,
	input  logic                                cfg_wen,
	input  logic [pcs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pcs_pkg::VALUE_W-1:0]         cfg_wdata
);

	pcs_pkg::ucw_t                          uw;
	logic [pcs_pkg::UPC_W-1:0]              upc_q;
	logic [pcs_pkg::UPC_W-1:0]              upc_d;
	logic [pcs_pkg::UPC_W-1:0]              upc_inc;

	logic signed [pcs_pkg::VALUE_W-1:0]     gain_p_q;
	logic signed [pcs_pkg::VALUE_W-1:0]     gain_i_q;
	logic signed [pcs_pkg::VALUE_W-1:0]     gain_d_q;
	logic signed [pcs_pkg::VALUE_W-1:0]     floor_q;
	logic signed [pcs_pkg::VALUE_W-1:0]     ceil_q;
	logic [pcs_pkg::WINDUP_W-1:0]           windup_q;

	pcs_pkg::in_beat_t                      in_q;
	pcs_pkg::out_beat_t                     out_q;
	logic                                   out_valid_q;
	logic signed [pcs_pkg::VALUE_W-1:0]     err_q;
	logic signed [pcs_pkg::VALUE_W-1:0]     integ_q;
	logic signed [pcs_pkg::VALUE_W-1:0]     prior_q;
	logic signed [pcs_pkg::VALUE_W-1:0]     drive_q;
	logic                                   held_q;
	logic signed [pcs_pkg::PROD_W-1:0]      prod_q;
	logic signed [pcs_pkg::ACC_W-1:0]       acc_q;

	logic                                   in_fire;
	logic                                   hold;
	logic                                   out_full;
	logic                                   emit_go;
	logic                                   div_start;
	logic                                   div_busy;
	logic signed [pcs_pkg::VALUE_W-1:0]     deriv;
	logic signed [pcs_pkg::VALUE_W:0]       err_delta;

	logic signed [pcs_pkg::VALUE_W-1:0]     mul_a;
	logic signed [pcs_pkg::VALUE_W-1:0]     mul_b;
	logic signed [pcs_pkg::VALUE_W-1:0]     prod_r;
	logic signed [pcs_pkg::VALUE_W:0]       err_diff;
	logic signed [pcs_pkg::VALUE_W-1:0]     err_new;
	logic signed [pcs_pkg::VALUE_W:0]       integ_sum;
	logic signed [pcs_pkg::VALUE_W-1:0]     integ_sat;
	logic signed [pcs_pkg::VALUE_W-1:0]     win_pos;
	logic signed [pcs_pkg::VALUE_W-1:0]     win_neg;
	logic signed [pcs_pkg::VALUE_W-1:0]     integ_new;
	logic signed [pcs_pkg::ACC_W-1:0]       prod_ext;
	logic signed [pcs_pkg::VALUE_W-1:0]     acc_sat;
	logic signed [pcs_pkg::VALUE_W-1:0]     drive_lo;
	logic signed [pcs_pkg::VALUE_W-1:0]     drive_new;

	// sequencer
	assign uw        = pcs_pkg::ucode(upc_q);
	assign upc_inc   = upc_q + 1'b1;
	assign in_ready  = (uw.act == pcs_pkg::ACT_FETCH);
	assign in_fire   = in_valid && in_ready;
	assign hold      = (in_q.time_step == '0);
	assign out_full  = out_valid_q && !out_ready;
	assign emit_go   = (uw.act == pcs_pkg::ACT_EMIT) && !out_full;
	assign div_start = (uw.act == pcs_pkg::ACT_DIV_START);

	always_comb begin
		unique case (uw.jc)
			pcs_pkg::JC_NEXT:     upc_d = upc_inc;
			pcs_pkg::JC_IF_HOLD:  upc_d = hold ? uw.target : upc_inc;
			pcs_pkg::JC_WAIT_IN:  upc_d = in_valid ? uw.target : upc_q;
			pcs_pkg::JC_WAIT_DIV: upc_d = div_busy ? upc_q : uw.target;
			pcs_pkg::JC_WAIT_OUT: upc_d = out_full ? upc_q : uw.target;
			default:              upc_d = uw.target;
		endcase
	end

	// shared multiplier operands
	always_comb begin
		unique case (uw.mul_sel)
			pcs_pkg::MS_ERR_DT: begin
				mul_a = err_q;
				mul_b = {{(pcs_pkg::VALUE_W-pcs_pkg::STEP_W){1'b0}}, in_q.time_step};
			end
			pcs_pkg::MS_P_ERR: begin
				mul_a = gain_p_q;
				mul_b = err_q;
			end
			pcs_pkg::MS_I_INT: begin
				mul_a = gain_i_q;
				mul_b = integ_q;
			end
			pcs_pkg::MS_D_DER: begin
				mul_a = gain_d_q;
				mul_b = deriv;
			end
		endcase
	end

	// datapath arithmetic
	assign prod_r    = pcs_pkg::mul_round(prod_q);
	assign err_diff  = {in_q.setpoint[pcs_pkg::VALUE_W-1], in_q.setpoint}
	                 - {in_q.measured_value[pcs_pkg::VALUE_W-1], in_q.measured_value};
	assign err_new   = pcs_pkg::sat_wide({err_diff[pcs_pkg::VALUE_W], err_diff});
	assign err_delta = {err_q[pcs_pkg::VALUE_W-1], err_q} - {prior_q[pcs_pkg::VALUE_W-1], prior_q};

	assign integ_sum = {integ_q[pcs_pkg::VALUE_W-1], integ_q}
	                 + {prod_r[pcs_pkg::VALUE_W-1], prod_r};
	assign integ_sat = pcs_pkg::sat_wide({integ_sum[pcs_pkg::VALUE_W], integ_sum});
	assign win_pos   = {1'b0, windup_q};
	assign win_neg   = -win_pos;

	always_comb begin
		priority if (integ_sat > win_pos)
			integ_new = win_pos;
		else if (integ_sat < win_neg)
			integ_new = win_neg;
		else
			integ_new = integ_sat;
	end

	assign prod_ext  = {{(pcs_pkg::ACC_W-pcs_pkg::VALUE_W){prod_r[pcs_pkg::VALUE_W-1]}}, prod_r};
	assign acc_sat   = pcs_pkg::sat_wide(acc_q);
	// floor first, then ceiling, so the ceiling wins when they cross
	assign drive_lo  = (acc_sat < floor_q) ? floor_q : acc_sat;
	assign drive_new = (drive_lo > ceil_q) ? ceil_q : drive_lo;

	pcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (err_delta),
		.divisor  (in_q.time_step),
		.busy     (div_busy),
		.quotient (deriv)
	);

	// control, configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= pcs_pkg::UPC_FETCH;
			out_valid_q <= 1'b0;
			gain_p_q    <= pcs_pkg::GAIN_ONE;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			floor_q     <= '0;
			ceil_q      <= '0;
			windup_q    <= '0;
			integ_q     <= '0;
			prior_q     <= '0;
			drive_q     <= '0;
		end else begin
			upc_q <= upc_d;
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_wen) begin
				unique case (cfg_index)
					pcs_pkg::REG_GAIN_P:        gain_p_q <= cfg_wdata;
					pcs_pkg::REG_GAIN_I:        gain_i_q <= cfg_wdata;
					pcs_pkg::REG_GAIN_D:        gain_d_q <= cfg_wdata;
					pcs_pkg::REG_DRIVE_FLOOR:   floor_q  <= cfg_wdata;
					pcs_pkg::REG_DRIVE_CEILING: ceil_q   <= cfg_wdata;
					pcs_pkg::REG_WINDUP_LIMIT:  windup_q <= cfg_wdata[pcs_pkg::WINDUP_W-1:0];
					default: ;
				endcase
			end
			if (uw.act == pcs_pkg::ACT_INTEG) begin
				integ_q <= integ_new;
				prior_q <= err_q;
			end
			if (uw.act == pcs_pkg::ACT_DRIVE)
				drive_q <= drive_new;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_fire)
			in_q <= in_data;
		if (uw.act == pcs_pkg::ACT_ERR) begin
			err_q  <= err_new;
			held_q <= hold;
		end
		if (uw.mul_en)
			prod_q <= mul_a * mul_b;
		unique case (uw.acc_op)
			pcs_pkg::ACC_LOAD: acc_q <= prod_ext;
			pcs_pkg::ACC_ADD:  acc_q <= acc_q + prod_ext;
			default: ;
		endcase
		if (emit_go) begin
			out_q.drive <= drive_q;
			out_q.held  <= held_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_busy)
		else $error("input taken while divider still busy");

	a_held_flag: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (out_valid && (out_data.held == (in_q.time_step == '0))))
		else $error("held flag does not match the beat's time step");

	a_drive_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.held && (floor_q <= ceil_q))
		|-> ((out_data.drive >= floor_q) && (out_data.drive <= ceil_q)))
		else $error("drive outside its limits");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for pid_controller_step_unit, one beat in gives one beat out
// random valid/ready gaps on both channels, fixed-point pid predictor in plain longint math
// depends on pcs_pkg and pid_controller_step_unit
module tb;

	localparam logic [pcs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [pcs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam longint VAL_TOP = 64'sd2147483647;
	localparam longint VAL_BOT = -VAL_TOP - 1;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	pcs_pkg::in_beat_t             in_data;
	logic                          out_valid;
	logic                          out_ready;
	pcs_pkg::out_beat_t            out_data;
	logic                          cfg_wen;
	logic [pcs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pcs_pkg::VALUE_W-1:0]   cfg_wdata;

	pcs_pkg::in_beat_t  sample_queue[$];
	pcs_pkg::out_beat_t drive_expect[$];
	int unsigned send_gap;
	int unsigned recv_stall;
	int unsigned fault_count;
	bit quiet;

	// predictor copy of registers and state
	longint kp_m, ki_m, kd_m, floor_m, ceil_m, wind_m;
	longint integ_m, prev_err_m, last_drive_m;

	pid_controller_step_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#25_000_000;
		$display("tb: done, errors");
		$finish;
	end

	function automatic longint clip_value(input longint v);
		if (v > VAL_TOP)
			return VAL_TOP;
		if (v < VAL_BOT)
			return VAL_BOT;
		return v;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return clip_value((a * b) >>> pcs_pkg::FRAC_W);
	endfunction

	function automatic pcs_pkg::out_beat_t pid_predict(input pcs_pkg::in_beat_t b);
		pcs_pkg::out_beat_t r;
		longint dt, err, integ, deriv, total;
		dt = longint'(b.time_step);
		if (dt == 0) begin
			r.drive = last_drive_m[pcs_pkg::VALUE_W-1:0];
			r.held  = 1'b1;
			return r;
		end
		err = clip_value(longint'(b.setpoint) - longint'(b.measured_value));
		integ = clip_value(integ_m + qmul(err, dt));
		if (integ > wind_m)
			integ = wind_m;
		if (integ < -wind_m)
			integ = -wind_m;
		integ_m = integ;
		deriv = clip_value(((err - prev_err_m) <<< pcs_pkg::FRAC_W) / dt);
		prev_err_m = err;
		total = clip_value(qmul(kp_m, err) + qmul(ki_m, integ) + qmul(kd_m, deriv));
		if (total < floor_m)
			total = floor_m;
		if (total > ceil_m)
			total = ceil_m;
		last_drive_m = total;
		r.drive = total[pcs_pkg::VALUE_W-1:0];
		r.held  = 1'b0;
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(30, 150);
	endfunction

	function automatic logic [31:0] jitter(input int unsigned span);
		logic [31:0] v;
		v = $urandom_range(0, span);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic logic [31:0] pick_edge();
		case ($urandom_range(0, 3))
			0: return pcs_pkg::VMIN;
			1: return pcs_pkg::VMAX;
			2: return 32'h0;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 9))
			0: return pcs_pkg::VMIN;
			1: return pcs_pkg::VMAX;
			2: return 32'h0;
			3, 4, 5, 6: return jitter(32'h4_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic pcs_pkg::in_beat_t rand_sample(input logic [31:0] aim,
			input logic [31:0] bias);
		pcs_pkg::in_beat_t b;
		case ($urandom_range(0, 9))
			0: begin
				b.measured_value = $urandom;
				b.setpoint       = $urandom;
			end
			1: begin
				b.measured_value = pick_edge();
				b.setpoint       = pick_edge();
			end
			default: begin
				// tracking a setpoint with a steady offset so the integral winds up
				b.setpoint       = aim;
				b.measured_value = aim - bias - jitter(32'h2000);
			end
		endcase
		case ($urandom_range(0, 19))
			0, 1: b.time_step = '0;
			2: b.time_step = 24'd1;
			3: b.time_step = 24'hFF_FFFF;
			4, 5: b.time_step = 24'($urandom);
			default: b.time_step = 24'($urandom_range(1, 24'h4000));
		endcase
		return b;
	endfunction

	task automatic add_sample(input logic [31:0] m, input logic [31:0] s, input logic [23:0] dt);
		pcs_pkg::in_beat_t b;
		b.measured_value = m;
		b.setpoint       = s;
		b.time_step      = dt;
		sample_queue.push_back(b);
	endtask

	task automatic set_reg(input logic [pcs_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			pcs_pkg::REG_GAIN_P:        kp_m    = longint'(signed'(val));
			pcs_pkg::REG_GAIN_I:        ki_m    = longint'(signed'(val));
			pcs_pkg::REG_GAIN_D:        kd_m    = longint'(signed'(val));
			pcs_pkg::REG_DRIVE_FLOOR:   floor_m = longint'(signed'(val));
			pcs_pkg::REG_DRIVE_CEILING: ceil_m  = longint'(signed'(val));
			pcs_pkg::REG_WINDUP_LIMIT:  wind_m  = longint'(val[pcs_pkg::WINDUP_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic program_all(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
			input logic [31:0] lo, input logic [31:0] hi, input logic [31:0] wl);
		// unused indexes must leave every register alone
		set_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
		set_reg(pcs_pkg::REG_GAIN_P, p);
		set_reg(pcs_pkg::REG_GAIN_I, i);
		set_reg(pcs_pkg::REG_GAIN_D, d);
		set_reg(pcs_pkg::REG_DRIVE_FLOOR, lo);
		set_reg(pcs_pkg::REG_DRIVE_CEILING, hi);
		set_reg(pcs_pkg::REG_WINDUP_LIMIT, wl);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// sample on the falling edge so nothing races the rising-edge traffic
	task automatic settle();
		@(negedge clk);
		while (sample_queue.size() != 0 || in_valid || drive_expect.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (sample_queue.size() != 0) begin
				in_valid <= 1'b1;
				in_data  <= sample_queue.pop_front();
				send_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// accepted input beat: predict its drive
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			drive_expect.push_back(pid_predict(in_data));
	end

	// output backpressure
	always @(posedge clk) begin : ready_gen
		int unsigned n;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			recv_stall <= 0;
		end else if (out_valid && out_ready) begin
			n = pick_gap();
			recv_stall <= n;
			out_ready  <= (n == 0);
		end else if (recv_stall != 0) begin
			recv_stall <= recv_stall - 1;
			out_ready  <= (recv_stall == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// output monitor
	always @(posedge clk) begin : beat_check
		pcs_pkg::out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (drive_expect.size() == 0) begin
				if (fault_count < 10)
					$display("tb: unexpected beat drive %0d held %0b",
						out_data.drive, out_data.held);
				fault_count++;
			end else begin
				want = drive_expect.pop_front();
				if (out_data.drive !== want.drive || out_data.held !== want.held) begin
					if (fault_count < 10)
						$display("tb: mismatch drive exp %0d got %0d, held exp %0b got %0b",
							want.drive, out_data.drive, want.held, out_data.held);
					fault_count++;
				end
			end
		end
	end

	initial begin
		logic [31:0] lo_v, hi_v, swap_v, aim, bias, wl;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		cfg_wen     = 1'b0;
		cfg_index   = '0;
		cfg_wdata   = '0;
		fault_count = 0;
		quiet       = 1'b0;
		kp_m = longint'(pcs_pkg::GAIN_ONE);
		ki_m = 0;
		kd_m = 0;
		floor_m = 0;
		ceil_m = 0;
		wind_m = 0;
		integ_m = 0;
		prev_err_m = 0;
		last_drive_m = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: floor and ceiling both zero
		add_sample(32'h0, 32'h0, 24'h0);
		add_sample(pcs_pkg::VMIN, pcs_pkg::VMAX, 24'hFF_FFFF);
		settle();

		// wide limits, error overflow both ways, hold, rounding of small terms
		program_all(32'h1_0000, 32'h8000, 32'h4000, pcs_pkg::VMIN, pcs_pkg::VMAX,
			32'h7FFF_FFFF);
		add_sample(pcs_pkg::VMIN, pcs_pkg::VMAX, 24'hFF_FFFF);
		add_sample(pcs_pkg::VMAX, pcs_pkg::VMIN, 24'h1);
		add_sample(32'h0, 32'h0, 24'h0);
		add_sample(32'h1, 32'h0, 24'h1_0000);
		add_sample(-32'sd5, 32'd7, 24'h3);
		add_sample(32'h1_2345, 32'h1_0000, 24'h1);
		add_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h80_0000);
		settle();

		// extreme gains, no integral room, floor above ceiling
		program_all(pcs_pkg::VMIN, pcs_pkg::VMAX, pcs_pkg::VMIN, 32'h1_0000, -32'sh1_0000,
			32'h0);
		add_sample(32'h1_0000, 32'h0, 24'h1_0000);
		add_sample(32'h0, 32'h1_0000, 24'h1_0000);
		add_sample(32'h0, 32'h0, 24'h0);
		settle();

		// small windup, written with the unused top bit set
		program_all(pcs_pkg::VMAX, pcs_pkg::VMAX, pcs_pkg::VMAX, -32'sh10_0000, 32'h10_0000,
			32'h8002_0000);
		repeat (4) add_sample(32'h0, 32'h7FFF, 24'h100);
		add_sample(32'h7FFF, 32'h0, 24'h100);
		add_sample(pcs_pkg::VMAX, pcs_pkg::VMAX, 24'hFF_FFFF);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			quiet = (ph % 4 == 3);
			lo_v = $urandom;
			hi_v = $urandom;
			if ($signed(lo_v) > $signed(hi_v)) begin
				swap_v = lo_v;
				lo_v   = hi_v;
				hi_v   = swap_v;
			end
			case ($urandom_range(0, 5))
				0: begin
					lo_v = pcs_pkg::VMIN;
					hi_v = pcs_pkg::VMAX;
				end
				1: begin
					swap_v = lo_v;
					lo_v   = hi_v;
					hi_v   = swap_v;
				end
				2: begin
					lo_v = -jitter(32'h80_0000);
					hi_v = lo_v + $urandom_range(0, 32'h100_0000);
				end
				default: ;
			endcase
			case ($urandom_range(0, 4))
				0: wl = 32'h0;
				1: wl = 32'h7FFF_FFFF;
				2: wl = $urandom;
				default: wl = $urandom_range(0, 32'h10_0000);
			endcase
			program_all(pick_gain(), pick_gain(), pick_gain(), lo_v, hi_v, wl);
			aim  = ($urandom_range(0, 3) == 0) ? $urandom : jitter(32'h100_0000);
			bias = jitter(32'h4000);
			for (int n = 0; n < 236; n++)
				sample_queue.push_back(rand_sample(aim, bias));
			settle();
		end
		quiet = 1'b0;

		repeat (60) @(posedge clk);
		if (drive_expect.size() != 0) begin
			$display("tb: %0d beats never came out", drive_expect.size());
			fault_count += drive_expect.size();
		end
		if (fault_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
